>>> hw/rtl/bml_pkg.sv
// Shared types, widths and angle constants for the bicycle model linearizer.
package bml_pkg;

	localparam int AX_W    = 40;  // atan CORDIC x/y width
	localparam int AZ_W    = 34;  // CORDIC angle accumulator width
	localparam int CX_W    = 34;  // cosine CORDIC x/y width
	localparam int DEN_W   = 47;  // divisor L*c*c
	localparam int Q_W     = 32;  // quotient bits produced by the divider chain
	localparam int MAX_ITER = 32;

	localparam logic [AX_W-1:0] ATAN_X0    = AX_W'(64'd67108864);
	localparam logic [CX_W-1:0] COS_GAIN   = CX_W'(64'd652032874);
	localparam logic [15:0]     ANGLE_MAX  = 16'd25736;
	localparam logic [15:0]     COS_ONE    = 16'd32768;
	localparam logic [31:0]     SAT_POS    = 32'h7FFF_FFFF;
	localparam logic [31:0]     SAT_NEG    = 32'h8000_0000;

	localparam logic [1:0] REG_WHEEL_BASE  = 2'd0;
	localparam logic [1:0] REG_STEER_LIMIT = 2'd1;
	localparam logic [1:0] REG_TIME_STEP   = 2'd2;

	localparam logic [29:0] ARC_TABLE [MAX_ITER] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
		30'h00000001, 30'h00000000
	};

	typedef struct packed {
		logic [30:0] pm;
		logic        pneg;
		logic        tneg;
		logic        tzero;
		logic [15:0] wb;
		logic [14:0] lim;
	} atan_side_t;

	typedef struct packed {
		logic [30:0] pm;
		logic        pneg;
		logic        dneg;
		logic [15:0] dr;
		logic [14:0] dm;
		logic [15:0] wb;
	} cos_side_t;

	typedef struct packed {
		logic [30:0]      pm;
		logic             pneg;
		logic             oneg;
		logic [15:0]      dr;
		logic [DEN_W-1:0] den;
		logic             g_zero;
		logic             g_ovf;
		logic             o_zero;
		logic             o_ovf;
	} div_side_t;

endpackage

>>> hw/rtl/bml_point_if.sv
// Input channel: one operating point per item.
interface bml_point_if;
	logic        valid;
	logic        ready;
	logic [15:0] speed;
	logic [15:0] path_curvature;

	modport source (output valid, output speed, output path_curvature, input ready);
	modport sink (input valid, input speed, input path_curvature, output ready);
endinterface

>>> hw/rtl/bml_terms_if.sv
// Output channel: linearized model terms per item.
interface bml_terms_if;
	logic        valid;
	logic        ready;
	logic [31:0] state_coupling;
	logic [31:0] steer_gain;
	logic [31:0] steer_offset;
	logic [15:0] reference_steer;

	modport source (output valid, output state_coupling, output steer_gain,
		output steer_offset, output reference_steer, input ready);
	modport sink (input valid, input state_coupling, input steer_gain,
		input steer_offset, input reference_steer, output ready);
endinterface

>>> hw/rtl/bml_cfg_if.sv
// Configuration write channel.
interface bml_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bml_atan_cell.sv
// One vectoring CORDIC step of the arctangent chain.
module bml_atan_cell #(
	parameter int STEP = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  logic signed [bml_pkg::AX_W-1:0] x_i,
	input  logic signed [bml_pkg::AX_W-1:0] y_i,
	input  logic signed [bml_pkg::AZ_W-1:0] z_i,
	input  bml_pkg::atan_side_t           side_i,
	output logic                          valid_q,
	output logic signed [bml_pkg::AX_W-1:0] x_q,
	output logic signed [bml_pkg::AX_W-1:0] y_q,
	output logic signed [bml_pkg::AZ_W-1:0] z_q,
	output bml_pkg::atan_side_t           side_q
);
	logic signed [bml_pkg::AX_W-1:0] dx, dy;
	logic signed [bml_pkg::AZ_W-1:0] arc;

	assign dx  = y_i >>> STEP;
	assign dy  = x_i >>> STEP;
	assign arc = $signed(bml_pkg::AZ_W'(bml_pkg::ARC_TABLE[STEP]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (!y_i[bml_pkg::AX_W-1]) begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + arc;
			end else begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - arc;
			end
		end
	end
endmodule

>>> hw/rtl/bml_cos_cell.sv
// One rotation CORDIC step of the cosine chain.
module bml_cos_cell #(
	parameter int STEP = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  logic signed [bml_pkg::CX_W-1:0] x_i,
	input  logic signed [bml_pkg::CX_W-1:0] y_i,
	input  logic signed [bml_pkg::AZ_W-1:0] z_i,
	input  bml_pkg::cos_side_t            side_i,
	output logic                          valid_q,
	output logic signed [bml_pkg::CX_W-1:0] x_q,
	output logic signed [bml_pkg::CX_W-1:0] y_q,
	output logic signed [bml_pkg::AZ_W-1:0] z_q,
	output bml_pkg::cos_side_t            side_q
);
	logic signed [bml_pkg::CX_W-1:0] dx, dy;
	logic signed [bml_pkg::AZ_W-1:0] arc;

	assign dx  = y_i >>> STEP;
	assign dy  = x_i >>> STEP;
	assign arc = $signed(bml_pkg::AZ_W'(bml_pkg::ARC_TABLE[STEP]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (!z_i[bml_pkg::AZ_W-1]) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - arc;
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + arc;
			end
		end
	end
endmodule

>>> hw/rtl/bml_div_cell.sv
// One restoring-division step for both the gain and the offset quotient.
module bml_div_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           valid_i,
	input  logic [bml_pkg::DEN_W-1:0]      rg_i,
	input  logic [bml_pkg::Q_W-1:0]        qg_i,
	input  logic [bml_pkg::DEN_W-1:0]      ro_i,
	input  logic [bml_pkg::Q_W-1:0]        qo_i,
	input  logic [bml_pkg::Q_W-1:0]        lo_i,
	input  bml_pkg::div_side_t             side_i,
	output logic                           valid_q,
	output logic [bml_pkg::DEN_W-1:0]      rg_q,
	output logic [bml_pkg::Q_W-1:0]        qg_q,
	output logic [bml_pkg::DEN_W-1:0]      ro_q,
	output logic [bml_pkg::Q_W-1:0]        qo_q,
	output logic [bml_pkg::Q_W-1:0]        lo_q,
	output bml_pkg::div_side_t             side_q
);
	logic [bml_pkg::DEN_W:0] tg, to;
	logic                    fit_g, fit_o;

	// Gain numerator has all-zero low bits; offset shifts in its next bit.
	assign tg    = {rg_i, 1'b0};
	assign to    = {ro_i, lo_i[bml_pkg::Q_W-1]};
	assign fit_g = tg >= {1'b0, side_i.den};
	assign fit_o = to >= {1'b0, side_i.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			lo_q   <= {lo_i[bml_pkg::Q_W-2:0], 1'b0};
			rg_q   <= fit_g ? bml_pkg::DEN_W'(tg - {1'b0, side_i.den})
				: bml_pkg::DEN_W'(tg);
			ro_q   <= fit_o ? bml_pkg::DEN_W'(to - {1'b0, side_i.den})
				: bml_pkg::DEN_W'(to);
			qg_q   <= {qg_i[bml_pkg::Q_W-2:0], fit_g};
			qo_q   <= {qo_i[bml_pkg::Q_W-2:0], fit_o};
		end
	end
endmodule

>>> hw/rtl/bicycle_model_linearizer.sv
// Top level: linearized kinematic bicycle model terms, one item per cycle while not held.
//
//   channel  | role            | payload
//   ---------+-----------------+---------------------------------------------
//   point    | operating point | speed Q8.8, path_curvature Q2.14
//   terms    | model terms     | state_coupling, steer_gain, steer_offset,
//            |                 | reference_steer
//   cfg      | register write  | index (0 wheel_base, 1 steer_limit,
//            |                 | 2 time_step), data
//
// With N = min(ANGLE_ITERATIONS, 32) the pipeline is, in order: input
// stage, N atan cells, clamp stage, N cosine cells, three stages for the
// divisor, 32 divider cells and the output register. One item enters per
// cycle unless held. The whole pipeline advances together; it holds only
// while a result sits in the output register and terms.ready is low. Reset
// clears valid bits and restores the register defaults.
module bicycle_model_linearizer #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input logic               clk,
	input logic               arst_n,
	bml_point_if.sink         point,
	bml_terms_if.source       terms,
	bml_cfg_if.sink           cfg
);
	localparam int NI = (ANGLE_ITERATIONS > bml_pkg::MAX_ITER) ? bml_pkg::MAX_ITER
		: ANGLE_ITERATIONS;
	localparam int AX_W  = bml_pkg::AX_W;
	localparam int AZ_W  = bml_pkg::AZ_W;
	localparam int CX_W  = bml_pkg::CX_W;
	localparam int DEN_W = bml_pkg::DEN_W;
	localparam int Q_W   = bml_pkg::Q_W;

	// Configuration registers
	logic [15:0] wheel_base_q;
	logic [14:0] steer_limit_q;
	logic [15:0] time_step_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_base_q  <= 16'd11264;
			steer_limit_q <= 15'd9152;
			time_step_q   <= 16'd6554;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bml_pkg::REG_WHEEL_BASE:  wheel_base_q  <= cfg.data;
				bml_pkg::REG_STEER_LIMIT: steer_limit_q <= cfg.data[14:0];
				bml_pkg::REG_TIME_STEP:   time_step_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Global advance: move everything unless the output item is stuck.
	logic out_valid_q;
	logic en;
	assign en          = !out_valid_q || terms.ready;
	assign point.ready = en;

	// Stage 1: products v*dt and L*k
	logic signed [32:0] p_full, t_full;
	assign p_full = $signed(point.speed) * $signed({1'b0, time_step_q});
	assign t_full = $signed({1'b0, wheel_base_q}) * $signed(point.path_curvature);

	logic                valid_s1;
	bml_pkg::atan_side_t side_s1;
	logic [30:0]         tmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.pm    <= 31'(p_full[32] ? -p_full : p_full);
			side_s1.pneg  <= p_full[32];
			side_s1.tneg  <= t_full[32];
			side_s1.tzero <= (t_full == '0);
			side_s1.wb    <= wheel_base_q;
			side_s1.lim   <= steer_limit_q;
			tmag_s1       <= 31'(t_full[32] ? -t_full : t_full);
		end
	end

	// Arctangent chain
	logic                       av [NI+1];
	logic signed [AX_W-1:0]     ax [NI+1];
	logic signed [AX_W-1:0]     ay [NI+1];
	logic signed [AZ_W-1:0]     az [NI+1];
	bml_pkg::atan_side_t        aside [NI+1];

	assign av[0]    = valid_s1;
	assign ax[0]    = bml_pkg::ATAN_X0;
	assign ay[0]    = $signed(AX_W'(tmag_s1));
	assign az[0]    = '0;
	assign aside[0] = side_s1;

	for (genvar g = 0; g < NI; g++) begin : g_atan
		bml_atan_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(av[g]), .x_i(ax[g]), .y_i(ay[g]), .z_i(az[g]), .side_i(aside[g]),
			.valid_q(av[g+1]), .x_q(ax[g+1]), .y_q(ay[g+1]), .z_q(az[g+1]),
			.side_q(aside[g+1])
		);
	end

	// Stage 2: round to Q2.14, clamp, apply sign and steer limit
	bml_pkg::atan_side_t      sa;
	logic signed [AZ_W-1:0]   zr;
	logic signed [AZ_W-17:0]  dq;
	logic [15:0]              dabs;
	logic [15:0]              dr_c;
	logic [14:0]              dm_c;

	assign sa = aside[NI];
	assign zr = az[NI] + AZ_W'(32768);
	assign dq = (AZ_W-16)'(zr >>> 16);

	always_comb begin
		if (sa.tzero || dq[AZ_W-17]) begin
			dabs = '0;
		end else if (dq > $signed({2'b0, bml_pkg::ANGLE_MAX})) begin
			dabs = bml_pkg::ANGLE_MAX;
		end else begin
			dabs = dq[15:0];
		end
		dr_c = sa.tneg ? 16'(-dabs) : dabs;
		dm_c = (dabs >= {1'b0, sa.lim}) ? ((dabs == '0) ? '0 : sa.lim) : dabs[14:0];
	end

	logic               valid_s2;
	bml_pkg::cos_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= av[NI];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.pm   <= sa.pm;
			side_s2.pneg <= sa.pneg;
			side_s2.dneg <= sa.tneg && !sa.tzero && (dabs != '0);
			side_s2.dr   <= dr_c;
			side_s2.dm   <= dm_c;
			side_s2.wb   <= sa.wb;
		end
	end

	// Cosine chain
	logic                   cv [NI+1];
	logic signed [CX_W-1:0] cx [NI+1];
	logic signed [CX_W-1:0] cy [NI+1];
	logic signed [AZ_W-1:0] cz [NI+1];
	bml_pkg::cos_side_t     cside [NI+1];

	assign cv[0]    = valid_s2;
	assign cx[0]    = bml_pkg::COS_GAIN;
	assign cy[0]    = '0;
	assign cz[0]    = $signed(AZ_W'({side_s2.dm, 16'b0}));
	assign cside[0] = side_s2;

	for (genvar g = 0; g < NI; g++) begin : g_cos
		bml_cos_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(cv[g]), .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .side_i(cside[g]),
			.valid_q(cv[g+1]), .x_q(cx[g+1]), .y_q(cy[g+1]), .z_q(cz[g+1]),
			.side_q(cside[g+1])
		);
	end

	// Stage 3: cosine to Q1.15, offset numerator |v*dt|*|delta_c|
	logic signed [CX_W-1:0]  cr;
	logic signed [CX_W-16:0] cq;
	logic [15:0]             c_c;

	assign cr = cx[NI] + CX_W'(16384);
	assign cq = (CX_W-15)'(cr >>> 15);

	always_comb begin
		if (cq[CX_W-16]) begin
			c_c = '0;
		end else if (cq > $signed({3'b0, bml_pkg::COS_ONE})) begin
			c_c = bml_pkg::COS_ONE;
		end else begin
			c_c = cq[15:0];
		end
	end

	logic               valid_s3, valid_s4, valid_s5;
	bml_pkg::cos_side_t side_s3, side_s4, side_s5;
	logic [15:0]        c_s3;
	logic [45:0]        num_s3, num_s4, num_s5;
	logic [31:0]        cc_s4;
	logic [DEN_W-1:0]   den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= cv[NI];
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stages 3 to 5: c, c*c, L*c*c
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= cside[NI];
			c_s3    <= c_c;
			num_s3  <= cside[NI].pm * cside[NI].dm;
			side_s4 <= side_s3;
			num_s4  <= num_s3;
			cc_s4   <= c_s3 * c_s3;
			side_s5 <= side_s4;
			num_s5  <= num_s4;
			den_s5  <= DEN_W'(side_s4.wb * cc_s4);
		end
	end

	// Divider setup: upper numerator part seeds the remainder; if it already
	// reaches the divisor the quotient needs more than 32 bits.
	logic [DEN_W-1:0]   g_hi, o_hi;
	bml_pkg::div_side_t dside0;

	assign g_hi = DEN_W'({side_s5.pm, 2'b0});
	assign o_hi = DEN_W'(num_s5 >> 12);

	always_comb begin
		dside0.pm     = side_s5.pm;
		dside0.pneg   = side_s5.pneg;
		dside0.oneg   = (side_s5.pneg == side_s5.dneg);
		dside0.dr     = side_s5.dr;
		dside0.den    = den_s5;
		dside0.g_zero = (side_s5.pm == '0);
		dside0.g_ovf  = (g_hi >= den_s5);
		dside0.o_zero = (num_s5 == '0);
		dside0.o_ovf  = (o_hi >= den_s5);
	end

	logic                dv [Q_W+1];
	logic [DEN_W-1:0]    rg [Q_W+1];
	logic [DEN_W-1:0]    ro [Q_W+1];
	logic [Q_W-1:0]      qg [Q_W+1];
	logic [Q_W-1:0]      qo [Q_W+1];
	logic [Q_W-1:0]      lo [Q_W+1];
	bml_pkg::div_side_t  dside [Q_W+1];

	assign dv[0]    = valid_s5;
	assign rg[0]    = dside0.g_ovf ? '0 : g_hi;
	assign ro[0]    = dside0.o_ovf ? '0 : o_hi;
	assign qg[0]    = '0;
	assign qo[0]    = '0;
	assign lo[0]    = {num_s5[11:0], 20'b0};
	assign dside[0] = dside0;

	for (genvar g = 0; g < Q_W; g++) begin : g_div
		bml_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .valid_i(dv[g]),
			.rg_i(rg[g]), .qg_i(qg[g]), .ro_i(ro[g]), .qo_i(qo[g]), .lo_i(lo[g]),
			.side_i(dside[g]),
			.valid_q(dv[g+1]), .rg_q(rg[g+1]), .qg_q(qg[g+1]), .ro_q(ro[g+1]),
			.qo_q(qo[g+1]), .lo_q(lo[g+1]), .side_q(dside[g+1])
		);
	end

	// Output: saturate, apply sign, hold until taken
	bml_pkg::div_side_t sf;
	logic [31:0]        cap_g, cap_o, mag_g, mag_o, pc;

	assign sf    = dside[Q_W];
	assign cap_g = sf.pneg ? bml_pkg::SAT_NEG : bml_pkg::SAT_POS;
	assign cap_o = sf.oneg ? bml_pkg::SAT_NEG : bml_pkg::SAT_POS;
	assign pc    = {9'b0, sf.pm[30:8]};

	always_comb begin
		if (sf.g_zero) begin
			mag_g = '0;
		end else if (sf.g_ovf || qg[Q_W] > cap_g) begin
			mag_g = cap_g;
		end else begin
			mag_g = qg[Q_W];
		end
		if (sf.o_zero) begin
			mag_o = '0;
		end else if (sf.o_ovf || qo[Q_W] > cap_o) begin
			mag_o = cap_o;
		end else begin
			mag_o = qo[Q_W];
		end
	end

	logic [31:0] sc_q, sg_q, so_q;
	logic [15:0] rs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_q <= sf.pneg ? -pc : pc;
			sg_q <= sf.pneg ? -mag_g : mag_g;
			so_q <= sf.oneg ? -mag_o : mag_o;
			rs_q <= sf.dr;
		end
	end

	assign terms.valid           = out_valid_q;
	assign terms.state_coupling  = sc_q;
	assign terms.steer_gain      = sg_q;
	assign terms.steer_offset    = so_q;
	assign terms.reference_steer = rs_q;
endmodule
